/* rtl/core/spmc_pkg.sv */
// Package for the two-key shortest path unit: widths, codes, command and
// status structs shared by controller and datapath. No dependencies.
package spmc_pkg;

    localparam int MAX_NODES = 32;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int WEIGHT_W  = 16;
    localparam int SUM_W     = 21;
    localparam int MEM_AW    = 2 * NODE_W;
    localparam int EDGE_W    = 1 + 2 * WEIGHT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Item function codes
    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_RUN   = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_SOURCE     = 2'd1,
        CFG_DEST       = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_step;
        logic edge_wr;
        logic run_init;
        logic cnt_clr;
        logic sel_issue;
        logic sel_end;
        logic rel_issue;
        logic fin_issue;
        logic walk_wr;
        logic walk_rd;
        logic walk_load;
        logic emit_rd;
        logic emit_put;
        logic nf_put;
    } spmc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic n_zero;
        logic j_last;
        logic have;
        logic found;
        logic walk_stop;
        logic k_zero;
        logic out_free;
    } spmc_stat_t;

    // Add with saturation at the field maximum
    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a,
                                                 logic [WEIGHT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

/* rtl/core/spmc_ifs.sv */
// Valid/ready channel interfaces for the shortest path unit.
// Depends on spmc_pkg for field widths.
interface spmc_req_if
    import spmc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] edge_length;
    logic [WEIGHT_W-1:0] edge_cost;

    modport source (output valid, func, node_a, node_b, edge_length, edge_cost,
                    input ready);
    modport sink (input valid, func, node_a, node_b, edge_length, edge_cost,
                  output ready);
endinterface

interface spmc_rsp_if
    import spmc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] vertex;
    logic [SUM_W-1:0]  total_distance;
    logic [SUM_W-1:0]  total_cost;
    logic              found;
    logic              last;

    modport source (output valid, vertex, total_distance, total_cost, found, last,
                    input ready);
    modport sink (input valid, vertex, total_distance, total_cost, found, last,
                  output ready);
endinterface

/* rtl/core/spmc_ctrl.sv */
// Sequencer of the shortest path unit: clear sweep, edge loads, search
// phases, path walk and emission. Depends on spmc_pkg.
module spmc_ctrl
    import spmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_func,
    output logic       req_ready,
    input  spmc_stat_t stat,
    output spmc_cmd_t  cmd
);

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_INIT    = 14'b00000000000100,
        ST_SEL     = 14'b00000000001000,
        ST_SELW    = 14'b00000000010000,
        ST_SELEND  = 14'b00000000100000,
        ST_REL     = 14'b00000001000000,
        ST_RELW    = 14'b00000010000000,
        ST_FIN     = 14'b00000100000000,
        ST_NF      = 14'b00001000000000,
        ST_WALKW   = 14'b00010000000000,
        ST_WALKR   = 14'b00100000000000,
        ST_EMITRD  = 14'b01000000000000,
        ST_EMITPUT = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    func_t  fn;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign fn        = func_t'(req_func);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (fn)
                        FN_ADD:   cmd.edge_wr = 1'b1;
                        FN_RUN:   state_next = ST_INIT;
                        FN_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:
            begin
                cmd.run_init = 1'b1;
                cmd.cnt_clr  = 1'b1;
                state_next   = stat.n_zero ? ST_FIN : ST_SEL;
            end
            ST_SEL:
            begin
                cmd.sel_issue = 1'b1;
                if (stat.j_last)
                begin
                    state_next = ST_SELW;
                end
            end
            ST_SELW:
            begin
                state_next = ST_SELEND;
            end
            ST_SELEND:
            begin
                if (stat.have)
                begin
                    cmd.sel_end = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_REL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_REL:
            begin
                cmd.rel_issue = 1'b1;
                if (stat.j_last)
                begin
                    state_next = ST_RELW;
                end
            end
            ST_RELW:
            begin
                cmd.cnt_clr = 1'b1;
                state_next  = ST_SEL;
            end
            ST_FIN:
            begin
                cmd.fin_issue = 1'b1;
                state_next    = stat.found ? ST_WALKW : ST_NF;
            end
            ST_NF:
            begin
                if (stat.out_free)
                begin
                    cmd.nf_put = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WALKW:
            begin
                cmd.walk_wr = 1'b1;
                if (stat.walk_stop)
                begin
                    state_next = ST_EMITRD;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = ST_WALKR;
                end
            end
            ST_WALKR:
            begin
                cmd.walk_load = 1'b1;
                state_next    = ST_WALKW;
            end
            ST_EMITRD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMITPUT;
            end
            ST_EMITPUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_put = 1'b1;
                    state_next   = stat.k_zero ? ST_IDLE : ST_EMITRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/spmc_dp.sv */
// Datapath of the shortest path unit: edge memory, distance/cost/predecessor
// arrays, path buffer, config registers and output register. Depends on spmc_pkg.
module spmc_dp
    import spmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic [NODE_W-1:0]    node_a,
    input  logic [NODE_W-1:0]    node_b,
    input  logic [WEIGHT_W-1:0]  edge_length,
    input  logic [WEIGHT_W-1:0]  edge_cost,
    input  spmc_cmd_t            cmd,
    output spmc_stat_t           stat,
    spmc_rsp_if.source           rsp
);

    // Memories
    logic [EDGE_W-1:0] edge_mem [2**MEM_AW];
    logic [SUM_W-1:0]  dist_mem [MAX_NODES];
    logic [SUM_W-1:0]  cost_mem [MAX_NODES];
    logic [NODE_W-1:0] pred_mem [MAX_NODES];
    logic [NODE_W-1:0] pbuf_mem [MAX_NODES];

    logic [EDGE_W-1:0] edge_q;
    logic [SUM_W-1:0]  dist_q, cost_q;
    logic [NODE_W-1:0] pred_q, pbuf_q;

    // Config registers
    logic [CNT_W-1:0]  node_count_reg;
    logic [NODE_W-1:0] source_reg, dest_reg;
    logic [CNT_W-1:0]  n_eff;

    // Control and search registers
    logic [MEM_AW-1:0]    clr_addr_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [NODE_W-1:0]    jd_reg;
    logic                 sel_vld_reg, rel_vld_reg;
    logic [MAX_NODES-1:0] visited_reg, reached_reg;
    logic                 have_reg;
    logic [NODE_W-1:0]    u_reg;
    logic [SUM_W-1:0]     ubest_reg, ucost_reg;
    logic [NODE_W-1:0]    v_reg;
    logic [CNT_W-1:0]     len_reg;
    logic [NODE_W-1:0]    k_reg;

    // Output register
    logic              out_valid_reg;
    logic [NODE_W-1:0] out_vertex_reg;
    logic [SUM_W-1:0]  out_dist_reg, out_cost_reg;
    logic              out_found_reg, out_last_reg;

    logic              src_ok;
    logic [NODE_W-1:0] j_idx;
    logic [MEM_AW-1:0] edge_waddr, edge_raddr;
    logic [NODE_W-1:0] dc_raddr;
    logic              dc_ren;
    logic [SUM_W-1:0]  nd, nc;
    logic              present, upd, tie, rel_wr;
    logic              cand, better;
    logic              dc_we;
    logic [NODE_W-1:0] dc_waddr;
    logic [SUM_W-1:0]  dist_wdata, cost_wdata;
    logic [NODE_W-1:0] pred_wdata;
    logic              out_free;

    assign n_eff  = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                         : node_count_reg;
    assign src_ok = {1'b0, source_reg} < n_eff;
    assign j_idx  = j_reg[NODE_W-1:0];

    // Edge memory addressing: one triangle holds both directions
    assign edge_waddr = (node_a < node_b) ? {node_a, node_b} : {node_b, node_a};
    assign edge_raddr = (u_reg < j_idx) ? {u_reg, j_idx} : {j_idx, u_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            edge_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.edge_wr)
        begin
            edge_mem[edge_waddr] <= {1'b1, edge_length, edge_cost};
        end
        if (cmd.rel_issue)
        begin
            edge_q <= edge_mem[edge_raddr];
        end
    end

    // Relax arithmetic on the data read last cycle
    assign present = edge_q[EDGE_W-1];
    assign nd      = sat_add(ubest_reg, edge_q[2*WEIGHT_W-1:WEIGHT_W]);
    assign nc      = sat_add(ucost_reg, edge_q[WEIGHT_W-1:0]);
    assign upd     = !reached_reg[jd_reg] || (nd < dist_q);
    assign tie     = (nd == dist_q) && (nc < cost_q);
    assign rel_wr  = rel_vld_reg && present && !visited_reg[jd_reg] && (upd || tie);

    // Distance, cost and predecessor arrays
    assign dc_ren   = cmd.sel_issue || cmd.rel_issue || cmd.fin_issue;
    assign dc_raddr = cmd.fin_issue ? dest_reg : j_idx;
    assign dc_we    = (cmd.run_init && src_ok) || rel_wr;
    assign dc_waddr = cmd.run_init ? source_reg : jd_reg;
    assign dist_wdata = cmd.run_init ? '0 : nd;
    assign cost_wdata = cmd.run_init ? '0 : nc;
    assign pred_wdata = cmd.run_init ? source_reg : u_reg;

    always_ff @(posedge clk)
    begin
        if (dc_we)
        begin
            dist_mem[dc_waddr] <= dist_wdata;
            cost_mem[dc_waddr] <= cost_wdata;
            pred_mem[dc_waddr] <= pred_wdata;
        end
        if (dc_ren)
        begin
            dist_q <= dist_mem[dc_raddr];
            cost_q <= cost_mem[dc_raddr];
        end
        if (cmd.walk_rd)
        begin
            pred_q <= pred_mem[v_reg];
        end
    end

    // Path buffer
    always_ff @(posedge clk)
    begin
        if (cmd.walk_wr)
        begin
            pbuf_mem[len_reg[NODE_W-1:0]] <= v_reg;
        end
        if (cmd.emit_rd)
        begin
            pbuf_q <= pbuf_mem[k_reg];
        end
    end

    // Selection compare on the data read last cycle
    assign cand   = sel_vld_reg && !visited_reg[jd_reg] && reached_reg[jd_reg];
    assign better = !have_reg || (dist_q < ubest_reg);

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(MAX_NODES);
            source_reg     <= '0;
            dest_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NODE_COUNT: node_count_reg <= cfg_data[CNT_W-1:0];
                CFG_SOURCE:     source_reg     <= cfg_data[NODE_W-1:0];
                CFG_DEST:       dest_reg       <= cfg_data[NODE_W-1:0];
                default:        node_count_reg <= node_count_reg;
            endcase
        end
    end

    // Search control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            j_reg        <= '0;
            sel_vld_reg  <= 1'b0;
            rel_vld_reg  <= 1'b0;
            visited_reg  <= '0;
            reached_reg  <= '0;
            have_reg     <= 1'b0;
            len_reg      <= '0;
            k_reg        <= '0;
        end
        else
        begin
            sel_vld_reg <= cmd.sel_issue;
            rel_vld_reg <= cmd.rel_issue;
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            // clear or advance the column counter
            if (cmd.cnt_clr)
            begin
                j_reg <= '0;
            end
            else if (cmd.sel_issue || cmd.rel_issue)
            begin
                j_reg <= j_reg + 1'b1;
            end
            // visited and reached flags
            if (cmd.run_init)
            begin
                visited_reg <= '0;
                reached_reg <= '0;
                if (src_ok)
                begin
                    reached_reg[source_reg] <= 1'b1;
                end
            end
            else
            begin
                if (cmd.sel_end)
                begin
                    visited_reg[u_reg] <= 1'b1;
                end
                if (rel_wr)
                begin
                    reached_reg[jd_reg] <= 1'b1;
                end
            end
            // best candidate flag
            if (cmd.cnt_clr)
            begin
                have_reg <= 1'b0;
            end
            else if (cand && better)
            begin
                have_reg <= 1'b1;
            end
            // path walk length and emit index
            if (cmd.fin_issue)
            begin
                len_reg <= '0;
            end
            else if (cmd.walk_wr)
            begin
                len_reg <= len_reg + 1'b1;
                k_reg   <= len_reg[NODE_W-1:0];
            end
            else if (cmd.emit_put)
            begin
                k_reg <= k_reg - 1'b1;
            end
        end
    end

    // Search payload registers
    always_ff @(posedge clk)
    begin
        jd_reg <= j_idx;
        if (cand && better)
        begin
            u_reg     <= jd_reg;
            ubest_reg <= dist_q;
            ucost_reg <= cost_q;
        end
        if (cmd.fin_issue)
        begin
            v_reg <= dest_reg;
        end
        else if (cmd.walk_load)
        begin
            v_reg <= pred_q;
        end
    end

    // Output register
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_put || cmd.nf_put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_put)
        begin
            out_vertex_reg <= pbuf_q;
            out_dist_reg   <= dist_q;
            out_cost_reg   <= cost_q;
            out_found_reg  <= 1'b1;
            out_last_reg   <= (k_reg == '0);
        end
        else if (cmd.nf_put)
        begin
            out_vertex_reg <= '0;
            out_dist_reg   <= '0;
            out_cost_reg   <= '0;
            out_found_reg  <= 1'b0;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.vertex         = out_vertex_reg;
    assign rsp.total_distance = out_dist_reg;
    assign rsp.total_cost     = out_cost_reg;
    assign rsp.found          = out_found_reg;
    assign rsp.last           = out_last_reg;

    // Status to the controller
    assign stat.clr_done  = (clr_addr_reg == {MEM_AW{1'b1}});
    assign stat.n_zero    = (n_eff == '0);
    assign stat.j_last    = (j_reg == n_eff - 1'b1);
    assign stat.have      = have_reg;
    assign stat.found     = ({1'b0, dest_reg} < n_eff) && reached_reg[dest_reg];
    assign stat.walk_stop = (v_reg == source_reg) || (len_reg == CNT_W'(MAX_NODES - 1));
    assign stat.k_zero    = (k_reg == '0);
    assign stat.out_free  = out_free;

endmodule

/* rtl/core/shortest_path_min_cost_tiebreak_unit.sv */
// Top level of the two-key shortest path unit: controller plus datapath.
// Depends on spmc_pkg, spmc_ifs, spmc_ctrl and spmc_dp.
//
//   Channel  Dir  Handshake     Transaction
//   req      in   valid/ready   func, node_a, node_b, edge_length, edge_cost
//   rsp      out  valid/ready   vertex, total_distance, total_cost, found, last
//   cfg      in   cfg_we        cfg_index, cfg_data (no read-back)
//
// Add edge, unknown func: taken in IDLE, which they do not leave. Clear graph: a
// pass that zeroes every edge memory entry, also run once after reset. Search: INIT,
// then per settled vertex a minimum scan and a relaxation scan through the single
// edge memory port, a last minimum scan that finds none, then FIN. Walk back from
// the destination through the predecessors; emission of each result, source first.
// A stalled rsp holds emission in the output register; requests wait meanwhile.
module shortest_path_min_cost_tiebreak_unit
    import spmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    spmc_req_if.sink             req,
    spmc_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    spmc_cmd_t  cmd;
    spmc_stat_t stat;
    logic       ready;

    assign req.ready = ready;

    spmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spmc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .node_a      (req.node_a),
        .node_b      (req.node_b),
        .edge_length (req.edge_length),
        .edge_cost   (req.edge_cost),
        .cmd         (cmd),
        .stat        (stat),
        .rsp         (rsp)
    );

endmodule

/* sim/shortest_path_min_cost_tiebreak_unit_tb.sv */
// Testbench for the two-key shortest path unit: loads random graphs, runs searches
// and checks every field of each emitted result against a built-in path predictor.
// Depends on spmc_pkg, spmc_ifs and the unit's RTL.
`timescale 1ns / 1ps

module shortest_path_min_cost_tiebreak_unit_tb;
    import spmc_pkg::*;

    localparam int unsigned SAT_LIMIT = 2097151;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES = 2200;
    localparam int STALL_CYCLES = 400;

    typedef struct {
        func_t               fn;
        logic [NODE_W-1:0]   a;
        logic [NODE_W-1:0]   b;
        logic [WEIGHT_W-1:0] len;
        logic [WEIGHT_W-1:0] cost;
    } graph_cmd_t;

    typedef struct {
        logic [NODE_W-1:0] vertex;
        logic [SUM_W-1:0]  distance;
        logic [SUM_W-1:0]  cost;
        logic              found;
        logic              last;
    } hop_t;

    // Path predictor: graph copy, register copy and the queue of expected hops
    class path_scoreboard;
        logic [WEIGHT_W-1:0] len_m[MAX_NODES*MAX_NODES];
        logic [WEIGHT_W-1:0] cost_m[MAX_NODES*MAX_NODES];
        bit                  has_edge[MAX_NODES*MAX_NODES];
        int unsigned         nodes = 32;
        int unsigned         src = 0;
        int unsigned         dst = 0;
        hop_t                hop_q[$];
        int                  errors = 0;

        function void set_reg(cfg_idx_t idx, int unsigned val);
            case (idx)
                CFG_NODE_COUNT: nodes = val & 63;
                CFG_SOURCE:     src = val & 31;
                CFG_DEST:       dst = val & 31;
                default: ;
            endcase
        endfunction

        function void push_hop(int unsigned v, int unsigned d, int unsigned c, bit f, bit l);
            hop_t h;
            h.vertex = v[NODE_W-1:0];
            h.distance = d[SUM_W-1:0];
            h.cost = c[SUM_W-1:0];
            h.found = f;
            h.last = l;
            hop_q = {hop_q, h};
        endfunction

        // Dijkstra on length, strict least-cost tie-break, path emitted source first
        function void search();
            int unsigned n, i, j, u, idx, nd, nc, plen, v;
            bit          vis[MAX_NODES];
            bit          rch[MAX_NODES];
            int unsigned bd[MAX_NODES];
            int unsigned bc[MAX_NODES];
            int unsigned pred[MAX_NODES];
            int unsigned pathv[MAX_NODES];
            bit          have;
            n = (nodes < MAX_NODES) ? nodes : MAX_NODES;
            for (i = 0; i < MAX_NODES; i++)
            begin
                vis[i] = 0;
                rch[i] = 0;
                bd[i] = SAT_LIMIT;
                bc[i] = SAT_LIMIT;
                pred[i] = 0;
            end
            if (src < n)
            begin
                rch[src] = 1;
                bd[src] = 0;
                bc[src] = 0;
                pred[src] = src;
            end
            for (i = 0; i < n; i++)
            begin
                have = 0;
                u = 0;
                for (j = 0; j < n; j++)
                    if (!vis[j] && rch[j] && (!have || bd[j] < bd[u]))
                    begin
                        u = j;
                        have = 1;
                    end
                if (!have)
                    break;
                vis[u] = 1;
                for (j = 0; j < n; j++)
                begin
                    idx = u * MAX_NODES + j;
                    if (vis[j] || !has_edge[idx])
                        continue;
                    nd = bd[u] + len_m[idx];
                    nc = bc[u] + cost_m[idx];
                    if (nd > SAT_LIMIT)
                        nd = SAT_LIMIT;
                    if (nc > SAT_LIMIT)
                        nc = SAT_LIMIT;
                    if (!rch[j] || nd < bd[j])
                    begin
                        rch[j] = 1;
                        bd[j] = nd;
                        bc[j] = nc;
                        pred[j] = u;
                    end
                    else if (nd == bd[j] && nc < bc[j])
                    begin
                        bc[j] = nc;
                        pred[j] = u;
                    end
                end
            end
            if (dst >= n || !rch[dst])
            begin
                push_hop(0, 0, 0, 0, 1);
                return;
            end
            plen = 0;
            v = dst;
            while (plen < MAX_NODES)
            begin
                pathv[plen] = v;
                plen++;
                if (v == src)
                    break;
                v = pred[v % MAX_NODES];
            end
            for (i = 0; i < plen; i++)
                push_hop(pathv[plen-1-i], bd[dst], bc[dst], 1, (i + 1 == plen));
        endfunction

        function void note_request(graph_cmd_t c);
            int unsigned ab, ba;
            case (c.fn)
                FN_ADD:
                begin
                    ab = c.a * MAX_NODES + c.b;
                    ba = c.b * MAX_NODES + c.a;
                    len_m[ab] = c.len;
                    len_m[ba] = c.len;
                    cost_m[ab] = c.cost;
                    cost_m[ba] = c.cost;
                    has_edge[ab] = 1;
                    has_edge[ba] = 1;
                end
                FN_CLEAR:
                    foreach (has_edge[k])
                        has_edge[k] = 0;
                FN_RUN:
                    search();
                default: ;
            endcase
        endfunction

        function void check_hop(hop_t got);
            hop_t want;
            if (hop_q.size() == 0)
            begin
                $display("%0t: unexpected result vertex %0d", $time, got.vertex);
                errors++;
                return;
            end
            want = hop_q.pop_front();
            if (got.vertex !== want.vertex)
            begin
                $display("%0t: vertex expected %0d actual %0d", $time, want.vertex, got.vertex);
                errors++;
            end
            if (got.distance !== want.distance)
            begin
                $display("%0t: total_distance expected %0d actual %0d", $time, want.distance,
                         got.distance);
                errors++;
            end
            if (got.cost !== want.cost)
            begin
                $display("%0t: total_cost expected %0d actual %0d", $time, want.cost, got.cost);
                errors++;
            end
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    spmc_req_if req_ch ();
    spmc_rsp_if rsp_ch ();

    path_scoreboard sb = new();
    int  idle_cycles = 0;
    int  stall_asks = 0;
    int  stall_done = 0;
    bit  calm = 0;

    shortest_path_min_cost_tiebreak_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 13)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random back-pressure, plus long hold-offs on request
    initial
    begin
        int gap;
        gap = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_asks != stall_done)
            begin
                stall_done++;
                rsp_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                gap--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                gap = pick_gap();
            end
        end
    end

    // Check results and count idle cycles
    always @(posedge clk)
    begin
        hop_t got;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got.vertex = rsp_ch.vertex;
            got.distance = rsp_ch.total_distance;
            got.cost = rsp_ch.total_cost;
            got.found = rsp_ch.found;
            got.last = rsp_ch.last;
            sb.check_hop(got);
        end
        if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(graph_cmd_t c, int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= c.fn;
        req_ch.node_a <= c.a;
        req_ch.node_b <= c.b;
        req_ch.edge_length <= c.len;
        req_ch.edge_cost <= c.cost;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(c);
    endtask

    task automatic send_cmd(func_t fn, int a, int b, int len, int cost);
        graph_cmd_t c;
        c.fn = fn;
        c.a = NODE_W'(a);
        c.b = NODE_W'(b);
        c.len = WEIGHT_W'(len);
        c.cost = WEIGHT_W'(cost);
        send(c, pick_gap());
    endtask

    // Hold until every hop arrived, then let a clear pass finish
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.hop_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(int n, int s, int d);
        cfg_we <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_data <= CFG_DAT_W'(n);
        @(posedge clk);
        sb.set_reg(CFG_NODE_COUNT, n);
        cfg_index <= CFG_SOURCE;
        cfg_data <= CFG_DAT_W'(s);
        @(posedge clk);
        sb.set_reg(CFG_SOURCE, s);
        cfg_index <= CFG_DEST;
        cfg_data <= CFG_DAT_W'(d);
        @(posedge clk);
        sb.set_reg(CFG_DEST, d);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_weight();
        case ($urandom_range(0, 5))
            0:       return 65535;
            1:       return $urandom_range(0, 65535);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // Random phase: mostly edges inside the active nodes, runs interleaved
    task automatic random_phase(int n, int s, int d, int span, int count);
        int r, k;
        write_regs(n, s, d);
        send_cmd(FN_CLEAR, 0, 0, 0, 0);
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                send_cmd(FN_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                         pick_weight(), pick_weight());
            else if (r < 70)
                send_cmd(FN_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            else if (r < 92)
                send_cmd(FN_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            else if (r < 96)
                send_cmd(FN_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
                send_cmd(FN_CLEAR, 0, 0, 0, 0);
        end
        send_cmd(FN_RUN, 0, 0, 0, 0);
        drain();
    endtask

    initial
    begin
        int k;
        req_ch.valid = 1'b0;
        req_ch.func = FN_NONE;
        req_ch.node_a = '0;
        req_ch.node_b = '0;
        req_ch.edge_length = '0;
        req_ch.edge_cost = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: source equals destination at reset settings, ignored func
        send_cmd(FN_RUN, 0, 0, 0, 0);
        send_cmd(FN_NONE, 31, 31, 65535, 65535);
        drain();

        // Directed: long chain with extreme weights, self loop, tie on length
        write_regs(32, 0, 31);
        send_cmd(FN_ADD, 0, 1, 65535, 65535);
        send_cmd(FN_ADD, 1, 31, 65535, 0);
        send_cmd(FN_ADD, 0, 2, 0, 0);
        send_cmd(FN_ADD, 2, 31, 131070 - 65535, 100);
        send_cmd(FN_ADD, 31, 31, 0, 0);
        send_cmd(FN_ADD, 0, 3, 65535, 5);
        send_cmd(FN_ADD, 3, 31, 65535, 5);
        send_cmd(FN_RUN, 0, 0, 0, 0);
        send_cmd(FN_ADD, 0, 3, 65535, 65535);
        send_cmd(FN_RUN, 0, 0, 0, 0);
        drain();

        // Directed: destination unreachable, then out of range, zero count, count over the maximum and clear
        write_regs(32, 5, 7);
        send_cmd(FN_RUN, 0, 0, 0, 0);
        drain();
        write_regs(4, 1, 9);
        send_cmd(FN_RUN, 0, 0, 0, 0);
        drain();
        write_regs(0, 0, 0);
        send_cmd(FN_RUN, 0, 0, 0, 0);
        drain();
        write_regs(63, 31, 0);
        send_cmd(FN_RUN, 0, 0, 0, 0);
        send_cmd(FN_CLEAR, 0, 0, 0, 0);
        send_cmd(FN_RUN, 0, 0, 0, 0);
        drain();

        // Random phases over several register settings
        random_phase(1, 0, 0, 1, 8);
        random_phase(6, 2, 5, 6, 16);
        calm = 1;
        random_phase(32, 31, 0, 32, 18);
        calm = 0;
        random_phase(12, 0, 11, 12, 16);
        random_phase(63, 17, 30, 32, 16);
        random_phase(8, 7, 3, 8, 14);

        // Receiver holds off while runs keep coming, so the unit backs up
        write_regs(8, 0, 7);
        for (k = 0; k < 7; k++)
            send_cmd(FN_ADD, k, k + 1, $urandom_range(0, 3), $urandom_range(0, 3));
        stall_asks++;
        for (k = 0; k < 8; k++)
            send_cmd(FN_RUN, 0, 0, 0, 0);
        drain();

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
